// File: sv/imu_align_pkg.sv
// Shared types and constants for the IMU stream interpolation aligner.
`timescale 1ns / 1ps
package imu_align_pkg;
	localparam int AxisBits = 32;
	localparam int TimeBits = 48;
	localparam int HistDepth = 3;
	localparam int FracBits = 16;

	typedef logic signed [AxisBits-1:0] axis_t;
	typedef logic [TimeBits-1:0] stamp_t;
	typedef logic [1:0] status_t;

	localparam status_t StOk = 2'd0;
	localparam status_t StNotFull = 2'd1;
	localparam status_t StTooOld = 2'd2;
	localparam status_t StTooNew = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_DIV, S_MUL, S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;
		logic check;
		logic div_start;
		logic div_step;
		logic mul;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_slow;
		logic fault;
		logic div_done;
	} stat_t;
endpackage

// File: sv/imu_stream_interpolation_align.sv
// Top level of the IMU stream interpolation aligner.
`timescale 1ns / 1ps
// Takes gyro and accel samples and, for each sample of the slow sensor, emits one
// merged record with the slow sensor interpolated to the newest fast timestamp.
// A fast sample is only stored. A slow sample that interpolates passes through the
// 16-step serial divider that forms the Q1.16 factor; one whose two slow timestamps
// are equal skips the division, and one with an error status skips division and blend. The
// next sample is taken once the result sits in the output register, which holds
// until taken; a result still waiting there adds its wait to the slow sample.
module imu_stream_interpolation_align
	import imu_align_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: axis_x, axis_y, axis_z, sample_time
	input  logic [143:0] s_tdata,
	// tuser: sensor_kind
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, out_ts
	output logic [239:0] m_tdata,
	// tuser: status
	output logic [1:0] m_tuser
);
	logic slow_q, busy, out_set, mv_q;
	cmd_t cmd;
	stat_t stat;
	axis_t in_axis [3], og [3], oa [3];
	stamp_t ots;
	status_t ost;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) slow_q <= 1'b1;
		else if (cfg_valid) slow_q <= cfg_data;
	end

	assign s_tready = !busy;
	assign in_axis[0] = s_tdata[31:0];
	assign in_axis[1] = s_tdata[63:32];
	assign in_axis[2] = s_tdata[95:64];

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mv_q <= 1'b0;
		else if (out_set) mv_q <= 1'b1;
		else if (m_tready) mv_q <= 1'b0;
	end
	assign m_tvalid = mv_q;
	assign m_tuser = ost;
	assign m_tdata = {ots, oa[2], oa[1], oa[0], og[2], og[1], og[0]};

	imu_align_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && s_tready),
		.out_free(!mv_q || m_tready),
		.stat, .cmd, .busy, .out_set
	);

	imu_align_dp u_dp (
		.clk, .arst_n, .cmd, .stat,
		.slow_is_accel(slow_q),
		.in_kind(s_tuser),
		.in_axis,
		.in_time(s_tdata[143:96]),
		.out_status(ost),
		.out_gyro(og),
		.out_accel(oa),
		.out_ts(ots)
	);
endmodule

// File: sv/imu_align_dp.sv
// Datapath: sample histories, interval choice, serial divider and blend.
`timescale 1ns / 1ps
module imu_align_dp
	import imu_align_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output stat_t stat,
	input  logic slow_is_accel,
	input  logic in_kind,
	input  axis_t in_axis [3],
	input  stamp_t in_time,
	output status_t out_status,
	output axis_t out_gyro [3],
	output axis_t out_accel [3],
	output stamp_t out_ts
);
	axis_t g_ax_q [HistDepth][3];
	axis_t a_ax_q [HistDepth][3];
	stamp_t g_t_q [HistDepth];
	stamp_t a_t_q [HistDepth];
	logic [1:0] g_fill_q, a_fill_q;
	logic kind_q;
	status_t st_q;
	stamp_t tf_q, den_q, rem_q;
	logic [4:0] cnt_q;
	logic [FracBits:0] f_q;
	axis_t old_q [3], new_q [3], fast_q [3];
	axis_t res_q [3];

	// History shift on every accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_fill_q <= '0;
			a_fill_q <= '0;
			for (int i = 0; i < HistDepth; i++) begin
				g_t_q[i] <= '0;
				a_t_q[i] <= '0;
				for (int k = 0; k < 3; k++) begin
					g_ax_q[i][k] <= '0;
					a_ax_q[i][k] <= '0;
				end
			end
		end else if (cmd.store) begin
			if (in_kind) begin
				for (int i = HistDepth - 1; i > 0; i--) begin
					a_ax_q[i] <= a_ax_q[i-1];
					a_t_q[i] <= a_t_q[i-1];
				end
				a_ax_q[0] <= in_axis;
				a_t_q[0] <= in_time;
				if (a_fill_q != 2'(HistDepth)) a_fill_q <= a_fill_q + 2'd1;
			end else begin
				for (int i = HistDepth - 1; i > 0; i--) begin
					g_ax_q[i] <= g_ax_q[i-1];
					g_t_q[i] <= g_t_q[i-1];
				end
				g_ax_q[0] <= in_axis;
				g_t_q[0] <= in_time;
				if (g_fill_q != 2'(HistDepth)) g_fill_q <= g_fill_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) kind_q <= in_kind;
	end

	// Slow and fast views.
	stamp_t s_t [HistDepth];
	axis_t s_ax [HistDepth][3];
	stamp_t tf;
	logic full, use_old;
	always_comb begin
		s_t = slow_is_accel ? a_t_q : g_t_q;
		s_ax = slow_is_accel ? a_ax_q : g_ax_q;
		tf = slow_is_accel ? g_t_q[0] : a_t_q[0];
		full = (g_fill_q == 2'(HistDepth)) && (a_fill_q == 2'(HistDepth));
		use_old = tf < s_t[1];
	end

	// Interval check and divider.
	stamp_t t_o, t_n, twice;
	logic ge;
	always_comb begin
		t_o = use_old ? s_t[2] : s_t[1];
		t_n = use_old ? s_t[1] : s_t[0];
		twice = den_q - rem_q;
		ge = rem_q >= twice;
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			tf_q <= tf;
			old_q <= use_old ? s_ax[2] : s_ax[1];
			new_q <= use_old ? s_ax[1] : s_ax[0];
			fast_q <= slow_is_accel ? g_ax_q[0] : a_ax_q[0];
			if (!full) st_q <= StNotFull;
			else if (use_old && tf < s_t[2]) st_q <= StTooOld;
			else if (tf > t_n) st_q <= StTooNew;
			else st_q <= StOk;
			den_q <= t_n - t_o;
			rem_q <= tf - t_o;
		end else if (cmd.div_start) begin
			// Equal slow timestamps skip the division with a zero factor.
			cnt_q <= (den_q == '0) ? 5'd16 : 5'd0;
			if (den_q == '0) f_q <= '0;
			else if (rem_q >= den_q) begin
				f_q <= 17'd1;
				rem_q <= rem_q - den_q;
			end else f_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 5'd1;
			f_q <= {f_q[FracBits-1:0], ge};
			rem_q <= ge ? rem_q - twice : rem_q + rem_q;
		end
	end

	// Blend, one multiplier pair per axis.
	logic signed [AxisBits+FracBits+2:0] sum [3];
	always_comb begin
		for (int k = 0; k < 3; k++)
			sum[k] = old_q[k] * $signed({2'b0, 17'(65536) - f_q})
				+ new_q[k] * $signed({2'b0, f_q}) + 51'sd32768;
	end
	always_ff @(posedge clk) begin
		if (cmd.mul)
			for (int k = 0; k < 3; k++) res_q[k] <= axis_t'(sum[k] >>> FracBits);
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status <= st_q;
			if (st_q != StOk) begin
				for (int k = 0; k < 3; k++) begin
					out_gyro[k] <= '0;
					out_accel[k] <= '0;
				end
				out_ts <= '0;
			end else begin
				out_gyro <= slow_is_accel ? fast_q : res_q;
				out_accel <= slow_is_accel ? res_q : fast_q;
				out_ts <= tf_q;
			end
		end
	end

	assign stat.is_slow = kind_q == slow_is_accel;
	assign stat.fault = st_q != StOk;
	assign stat.div_done = cnt_q == 5'd16;
endmodule

// File: sv/imu_align_ctrl.sv
// Controller: sequences storing, checking, division, blend and output.
`timescale 1ns / 1ps
module imu_align_ctrl
	import imu_align_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic out_free,
	input  stat_t stat,
	output cmd_t cmd,
	output logic busy,
	output logic out_set
);
	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		out_set = 1'b0;
		busy = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: begin
				cmd.store = in_fire;
				if (in_fire) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.is_slow) begin
					cmd.check = 1'b1;
					state_d = S_DIV;
				end else state_d = S_IDLE;
			end
			S_DIV: begin
				if (stat.fault) state_d = S_OUT;
				else begin
					cmd.div_start = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				if (stat.div_done) begin
					cmd.mul = 1'b1;
					state_d = S_OUT;
				end else cmd.div_step = 1'b1;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					out_set = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: tb/imu_align_checker.sv
// Checker that predicts and compares the merged records of the IMU aligner.
`timescale 1ns / 1ps
module imu_align_checker
	import imu_align_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_data,
	input  logic s_tvalid,
	input  logic s_tready,
	input  logic [143:0] s_tdata,
	input  logic s_tuser,
	input  logic m_tvalid,
	input  logic m_tready,
	input  logic [239:0] m_tdata,
	input  logic [1:0] m_tuser,
	output int fail_count,
	output int pending_count
);
	typedef struct {
		status_t st;
		axis_t gyro [3];
		axis_t accel [3];
		stamp_t ts;
	} record_t;

	// Model history, newest entry first.
	axis_t gyro_axes [HistDepth][3];
	stamp_t gyro_stamps [HistDepth];
	int gyro_fill;
	axis_t accel_axes [HistDepth][3];
	stamp_t accel_stamps [HistDepth];
	int accel_fill;
	logic slow_accel;
	record_t merged_q [$];

	assign pending_count = merged_q.size();

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Append one expected record at the tail of the queue.
	task automatic expect_record(input record_t r);
		merged_q = {merged_q, r};
	endtask

	// Floor of num * 2^16 / den with num <= den.
	function automatic logic [16:0] interp_factor(input logic [48:0] num,
			input logic [48:0] den);
		logic [80:0] prod;
		prod = {32'd0, num} << 16;
		return 17'(prod / {32'd0, den});
	endfunction

	// Weighted sum rounded to nearest, ties upward.
	function automatic axis_t blend_axis(input axis_t older, input axis_t newer,
			input logic [16:0] f);
		logic signed [63:0] sum;
		sum = 64'(older) * $signed({47'd0, 17'd65536 - f})
			+ 64'(newer) * $signed({47'd0, f}) + 64'sd32768;
		return axis_t'(sum >>> 16);
	endfunction

	// Store the sample and, for a slow sample, predict its record.
	task automatic predict_sample(input logic kind, input axis_t xyz [3], input stamp_t t);
		record_t r;
		axis_t so [3], sn [3], fv [3], iv [3];
		stamp_t tf, t_old, t_new;
		logic [16:0] f;
		if (kind) begin
			for (int i = HistDepth - 1; i > 0; i--) begin
				accel_axes[i] = accel_axes[i-1];
				accel_stamps[i] = accel_stamps[i-1];
			end
			accel_axes[0] = xyz;
			accel_stamps[0] = t;
			if (accel_fill < HistDepth) accel_fill++;
		end else begin
			for (int i = HistDepth - 1; i > 0; i--) begin
				gyro_axes[i] = gyro_axes[i-1];
				gyro_stamps[i] = gyro_stamps[i-1];
			end
			gyro_axes[0] = xyz;
			gyro_stamps[0] = t;
			if (gyro_fill < HistDepth) gyro_fill++;
		end
		if (kind != slow_accel) return;
		r.st = StOk;
		r.ts = '0;
		for (int i = 0; i < 3; i++) begin
			r.gyro[i] = '0;
			r.accel[i] = '0;
		end
		if (gyro_fill < HistDepth || accel_fill < HistDepth) begin
			r.st = StNotFull;
			expect_record(r);
			return;
		end
		tf = slow_accel ? gyro_stamps[0] : accel_stamps[0];
		fv = slow_accel ? gyro_axes[0] : accel_axes[0];
		t_new = slow_accel ? accel_stamps[0] : gyro_stamps[0];
		sn = slow_accel ? accel_axes[0] : gyro_axes[0];
		t_old = slow_accel ? accel_stamps[1] : gyro_stamps[1];
		so = slow_accel ? accel_axes[1] : gyro_axes[1];
		if (tf < t_old) begin
			if (tf < (slow_accel ? accel_stamps[2] : gyro_stamps[2])) begin
				r.st = StTooOld;
				expect_record(r);
				return;
			end
			t_new = t_old;
			sn = so;
			t_old = slow_accel ? accel_stamps[2] : gyro_stamps[2];
			so = slow_accel ? accel_axes[2] : gyro_axes[2];
		end
		if (tf > t_new) begin
			r.st = StTooNew;
			expect_record(r);
			return;
		end
		f = (t_new == t_old) ? 17'd0 : interp_factor(tf - t_old, t_new - t_old);
		for (int i = 0; i < 3; i++) iv[i] = blend_axis(so[i], sn[i], f);
		r.gyro = slow_accel ? fv : iv;
		r.accel = slow_accel ? iv : fv;
		r.ts = tf;
		expect_record(r);
	endtask

	// Watch all three channels.
	always @(posedge clk or negedge arst_n) begin
		axis_t xyz [3];
		record_t w;
		if (!arst_n) begin
			gyro_fill = 0;
			accel_fill = 0;
			slow_accel = 1'b1;
			fail_count = 0;
			for (int i = 0; i < HistDepth; i++) begin
				gyro_stamps[i] = '0;
				accel_stamps[i] = '0;
				for (int j = 0; j < 3; j++) begin
					gyro_axes[i][j] = '0;
					accel_axes[i][j] = '0;
				end
			end
			merged_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (merged_q.size() == 0) begin
					report_mismatch("unexpected transaction", {62'd0, m_tuser}, '0);
				end else begin
					w = merged_q.pop_front();
					if (m_tuser !== w.st) report_mismatch("status", m_tuser, w.st);
					for (int i = 0; i < 3; i++) begin
						if (m_tdata[32*i +: 32] !== w.gyro[i])
							report_mismatch("gyro axis", m_tdata[32*i +: 32], w.gyro[i]);
						if (m_tdata[96 + 32*i +: 32] !== w.accel[i])
							report_mismatch("accel axis", m_tdata[96 + 32*i +: 32],
								w.accel[i]);
					end
					if (m_tdata[239:192] !== w.ts) report_mismatch("out_ts", m_tdata[239:192], w.ts);
				end
			end
			if (s_tvalid && s_tready) begin
				for (int i = 0; i < 3; i++) xyz[i] = s_tdata[32*i +: 32];
				predict_sample(s_tuser, xyz, s_tdata[143:96]);
			end
			if (cfg_valid && cfg_ready) slow_accel = cfg_data;
		end
	end
endmodule

// File: tb/imu_stream_interpolation_align_test.sv
// Testbench top for the IMU aligner: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module imu_stream_interpolation_align_test;
	import imu_align_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [143:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [239:0] m_tdata;
	logic [1:0] m_tuser;
	int fail_count;
	int pending_count;
	longint cycles = 0;
	logic slow_accel = 1'b1;
	stamp_t clock_now = 48'd1000;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	imu_stream_interpolation_align DUT (.*);
	imu_align_checker checker_i (.*);

	// Guard against a hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("** imu_stream_interpolation_align: FAILED **");
			$finish;
		end
	end

	// Receiver with random stalls; tready stays high across a zero gap.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic logic [31:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(0, 400000)) - 200000);
			default: return $urandom;
		endcase
	endfunction

	// Returns at the accepting edge with tvalid still high; the next call lowers it
	// only before a gap, and stop_input lowers it.
	task automatic send_sample(input logic kind, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input stamp_t t, input bit allow_gap);
		int gap;
		gap = (allow_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {t, z, y, x};
		s_tuser <= kind;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic stop_input();
		s_tvalid <= 1'b0;
	endtask

	task automatic send_random(input logic kind, input stamp_t t);
		send_sample(kind, rand_axis(), rand_axis(), rand_axis(), t, 1'b1);
	endtask

	task automatic drain_and_write(input logic value);
		stop_input();
		while (pending_count != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		slow_accel = value;
	endtask

	// One slow period: a few fast samples then a slow one, mostly in order.
	task automatic send_period();
		int n;
		stamp_t slow_t;
		n = $urandom_range(1, 4);
		slow_t = clock_now + 48'($urandom_range(1, 5000));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: send_random(!slow_accel, slow_t + 48'($urandom_range(1, 3000)));
				1: send_random(!slow_accel, clock_now - 48'($urandom_range(0, 12000)));
				default: send_random(!slow_accel,
					clock_now + 48'($urandom_range(0, 32'(slow_t - clock_now))));
			endcase
		end
		if ($urandom_range(0, 15) == 0) slow_t = clock_now;
		if ($urandom_range(0, 30) == 0) slow_t = {$urandom, $urandom} & 48'hffffffffffff;
		send_random(slow_accel, slow_t);
		clock_now = slow_t;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Directed: history not full, extreme values and timestamps, equal stamps.
		send_sample(1'b1, 32'h7fffffff, 32'h80000000, 32'h0, 48'd0, 1'b0);
		send_sample(1'b0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 48'd5, 1'b0);
		send_sample(1'b1, 32'h80000000, 32'h7fffffff, 32'h1, 48'd10, 1'b0);
		send_sample(1'b0, 32'h1, 32'h2, 32'h3, 48'd12, 1'b0);
		send_sample(1'b0, 32'h4, 32'h5, 32'h6, 48'd15, 1'b0);
		send_sample(1'b1, 32'h7fffffff, 32'h80000000, 32'hfffffffe, 48'd20, 1'b0);
		send_sample(1'b1, 32'h0, 32'h0, 32'h0, 48'd20, 1'b0);
		send_sample(1'b0, 32'h0, 32'h0, 32'h0, 48'd3, 1'b0);
		send_sample(1'b1, 32'h0, 32'h0, 32'h0, 48'd25, 1'b0);
		send_sample(1'b0, 32'h0, 32'h0, 32'h0, 48'd40, 1'b0);
		send_sample(1'b1, 32'h0, 32'h0, 32'h0, 48'd30, 1'b0);
		send_sample(1'b0, 32'hffffffff, 32'h80000000, 32'h7fffffff, 48'hffffffffffff, 1'b0);
		send_sample(1'b1, 32'h7fffffff, 32'h80000000, 32'h1, 48'hffffffffffff, 1'b0);
		send_sample(1'b0, 32'h12345678, 32'h9abcdef0, 32'h0, 48'hfffffffffff0, 1'b0);
		send_sample(1'b1, 32'h80000000, 32'h7fffffff, 32'h1, 48'hffffffffffff, 1'b0);
		send_sample(1'b1, 32'h80000000, 32'h7fffffff, 32'h1, 48'h0, 1'b0);
		send_sample(1'b1, 32'h80000000, 32'h7fffffff, 32'h1, 48'hffffffffffff, 1'b0);
		clock_now = 48'hffffffffffff - 48'd20000000;
		for (int i = 0; i < 40; i++) send_period();
		clock_now = 48'd100;
		drain_and_write(1'b0);
		for (int i = 0; i < 60; i++) send_period();
		drain_and_write(1'b1);
		for (int i = 0; i < 60; i++) send_period();
		drain_and_write(1'b0);
		for (int i = 0; i < 60; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_random($urandom_range(0, 1), {$urandom, $urandom} & 48'hffffffffffff);
			else send_period();
		end
		drain_and_write(1'b1);
		for (int i = 0; i < 40; i++) send_period();
		stop_input();
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0) begin
			$display("** imu_stream_interpolation_align: PASSED **");
		end else begin
			$display("** imu_stream_interpolation_align: FAILED **");
		end
		$finish;
	end
endmodule

// File: filelist.f
sv/imu_align_pkg.sv
sv/imu_align_dp.sv
sv/imu_align_ctrl.sv
sv/imu_stream_interpolation_align.sv
tb/imu_align_checker.sv
tb/imu_stream_interpolation_align_test.sv
